/* rtl/bmhpq_pkg.sv */
// Shared types and constants for the binary min-heap priority queue.
package bmhpq_pkg;

   localparam int CAPACITY     = 256;
   localparam int COUNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W        = 32;
   localparam int ITEM_COUNT_W = 9;
   localparam int STATUS_W     = 2;
   localparam int RSP_DATA_W   = ((2 * KEY_W + ITEM_COUNT_W + 7) / 8) * 8;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [KEY_W-1:0] key_type;

   // Command broadcast to every cell of the row in the cycle a request is taken.
   typedef struct packed {
      logic    insert;
      logic    extract;
      key_type key;
   } cell_ctrl_type;

endpackage

/* rtl/binary_min_heap_priority_queue.sv */
// Top level of the bounded min-first priority queue built from a row of key cells.
//
// Requests arrive on the req_ channel: req_tuser selects insert or extract of
// the minimum, req_tdata carries the signed key for an insert. Every request
// gives exactly one response on the rsp_ channel with the removed key, the
// new minimum, the new count and a status in rsp_tuser (done, insert refused
// because full, extract from empty).
// The keys live in a row of CAPACITY cells kept in ascending order. An insert
// compares the key against every cell at once and shifts the larger keys one
// cell right; an extract shifts the whole row one cell left. Either finishes
// in the cycle the request is taken. The response appears in the output
// register in the cycle after acceptance and a new request is taken in every
// cycle in which that register is empty or being emptied.
// While the receiver holds rsp_tready low the response stays in place and
// req_tready drops until it is taken.
// Reset empties the queue (count zero) and the response register at once; the
// cell contents are not cleared and are never read before being written.
module binary_min_heap_priority_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bmhpq_pkg::KEY_W-1:0]            req_tdata,  // [31:0] value
   input  logic                                   req_tuser,  // [0] operation
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [31:0] extracted, [63:32] top_value, [72:64] item_count, rest zero
   output logic [bmhpq_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [bmhpq_pkg::STATUS_W-1:0]         rsp_tuser   // [1:0] status
);

   localparam int CAP = bmhpq_pkg::CAPACITY;

   logic [bmhpq_pkg::COUNT_W-1:0]      count_ff;
   logic [bmhpq_pkg::COUNT_W-1:0]      count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   bmhpq_pkg::key_type                 rsp_extracted_ff;
   bmhpq_pkg::key_type                 rsp_extracted_in;
   bmhpq_pkg::key_type                 rsp_top_ff;
   bmhpq_pkg::key_type                 rsp_top_in;
   logic [bmhpq_pkg::ITEM_COUNT_W-1:0] rsp_count_ff;
   logic [bmhpq_pkg::ITEM_COUNT_W-1:0] rsp_count_in;
   logic [bmhpq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [bmhpq_pkg::STATUS_W-1:0]     rsp_status_in;

   logic                     req_accept;
   logic                     is_full;
   logic                     is_empty;
   bmhpq_pkg::cell_ctrl_type ctrl;
   logic [CAP-1:0]           cell_keep;
   bmhpq_pkg::key_type       cell_value [CAP];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign is_full    = (count_ff == bmhpq_pkg::COUNT_W'(CAP));
   assign is_empty   = (count_ff == '0);

   assign ctrl.key     = bmhpq_pkg::key_type'(req_tdata);
   assign ctrl.insert  = req_accept && (req_tuser == bmhpq_pkg::OP_INSERT) && !is_full;
   assign ctrl.extract = req_accept && (req_tuser == bmhpq_pkg::OP_EXTRACT) && !is_empty;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      bmhpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (bmhpq_pkg::COUNT_W'(i) < count_ff),
         .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
         .left_value  ((i == 0) ? ctrl.key : cell_value[(i == 0) ? 0 : i - 1]),
         .right_value ((i == CAP - 1) ? cell_value[i] : cell_value[(i == CAP - 1) ? i : i + 1]),
         .keep        (cell_keep[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_extracted_in = rsp_extracted_ff;
      rsp_top_in       = rsp_top_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_status_in    = rsp_status_ff;
      if (req_accept) begin
         rsp_valid_in     = 1'b1;
         rsp_extracted_in = '0;
         rsp_status_in    = bmhpq_pkg::STATUS_DONE;
         rsp_top_in       = is_empty ? bmhpq_pkg::key_type'(0) : cell_value[0];
         if (req_tuser == bmhpq_pkg::OP_INSERT) begin
            if (is_full) begin
               rsp_status_in = bmhpq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               if (is_empty || (ctrl.key < cell_value[0])) begin
                  rsp_top_in = ctrl.key;
               end
            end
         end else begin
            if (is_empty) begin
               rsp_status_in = bmhpq_pkg::STATUS_EMPTY;
            end else begin
               count_in         = count_ff - 1'b1;
               rsp_extracted_in = cell_value[0];
               rsp_top_in       = (count_ff == bmhpq_pkg::COUNT_W'(1)) ?
                                  bmhpq_pkg::key_type'(0) : cell_value[1];
            end
         end
         rsp_count_in = bmhpq_pkg::ITEM_COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_extracted_ff <= rsp_extracted_in;
      rsp_top_ff       <= rsp_top_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[bmhpq_pkg::KEY_W-1:0]                   = rsp_extracted_ff;
      rsp_tdata[2*bmhpq_pkg::KEY_W-1:bmhpq_pkg::KEY_W]  = rsp_top_ff;
      rsp_tdata[2*bmhpq_pkg::KEY_W +: bmhpq_pkg::ITEM_COUNT_W] = rsp_count_ff;
   end

`ifndef SYNTHESIS
   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance the count");

   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= bmhpq_pkg::COUNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
      else $error("cell row lost ascending order at its head");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bmhpq_pkg::STATUS_EMPTY) |->
      (rsp_count_ff == '0 && rsp_top_ff == 0))
      else $error("extract from empty reported a nonempty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bmhpq_pkg::COUNT_W'(CAP))
      else $error("count exceeds capacity");
`endif

endmodule

/* rtl/bmhpq_cell.sv */
// One cell of the sorted key row: holds one key and trades it with its neighbors.
module bmhpq_cell (
   input  logic                     clock,
   input  bmhpq_pkg::cell_ctrl_type ctrl,
   input  logic                     occupied,
   input  logic                     left_keep,
   input  bmhpq_pkg::key_type       left_value,
   input  bmhpq_pkg::key_type       right_value,
   output logic                     keep,
   output bmhpq_pkg::key_type       value
);

   bmhpq_pkg::key_type value_ff;
   bmhpq_pkg::key_type value_in;

   // The row is kept in ascending order, so the cells that keep their key on
   // an insert form a prefix; the first cell past it takes the new key.
   assign keep  = occupied && (value_ff <= ctrl.key);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (keep) begin
            value_in = value_ff;
         end else if (left_keep) begin
            value_in = ctrl.key;
         end else begin
            value_in = left_value;
         end
      end else if (ctrl.extract) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
